FILE: rtl/double_hash_counting_table_unit_assert.svh
`ifndef DOUBLE_HASH_COUNTING_TABLE_UNIT_ASSERT_SVH
`define DOUBLE_HASH_COUNTING_TABLE_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DHCT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dhct assertion failed");

// Check a property on every clock edge, reset included.
`define DHCT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("dhct assertion failed");

`endif

FILE: rtl/dhct_pkg.sv
package dhct_pkg;

   localparam int TABLE_SIZE = 1021;
   localparam int STEP_PRIME = 509;
   localparam int ALT_COUNT  = 4;
   localparam int KEY_BITS   = 64;
   localparam int CNT_BITS   = 32;
   localparam int KEY_BYTES  = KEY_BITS / 8;

   localparam int SLOT_W  = $clog2(TABLE_SIZE);
   localparam int STEP_W  = $clog2(STEP_PRIME + 1);
   localparam int PROBE_W = $clog2(TABLE_SIZE + 1);
   localparam int BYTE_W  = $clog2(KEY_BYTES);

   localparam logic [1:0] ACT_INC    = 2'd0;
   localparam logic [1:0] ACT_INC_ALT = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [1:0]           action;
      logic [KEY_BITS-1:0]  key;
      logic [ALT_COUNT-1:0] alt_mask;
      logic [SLOT_W-1:0]    home;
      logic [STEP_W-1:0]    step;
   } dhct_job_type;

   typedef struct packed {
      logic                                valid;
      logic [KEY_BITS-1:0]                 key;
      logic [CNT_BITS-1:0]                 count;
      logic [ALT_COUNT-1:0][CNT_BITS-1:0]  alt;
   } dhct_slot_type;

   typedef struct packed {
      logic [1:0]                          status;
      logic [CNT_BITS-1:0]                 count;
      logic [ALT_COUNT-1:0][CNT_BITS-1:0]  alt;
   } dhct_result_type;

   // One byte of a remainder: (r * 256 + b) mod m, with r < m < 1024.
   function automatic logic [SLOT_W-1:0] mod_byte(input logic [SLOT_W-1:0] r,
                                                  input logic [7:0] b,
                                                  input logic [SLOT_W-1:0] m);
      logic [SLOT_W+7:0] x;
      logic [SLOT_W+7:0] d;
      x = {r, b};
      for (int k = 7; k >= 0; k--) begin
         d = (SLOT_W + 8)'(m) << k;
         if (x >= d) begin
            x = x - d;
         end
      end
      return x[SLOT_W-1:0];
   endfunction

endpackage

FILE: rtl/dhct_front.sv
module dhct_front
   import dhct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [KEY_BITS-1:0]  req_key,
   input  logic [3:0]           req_alt_mask,
   input  logic                 clearing,
   input  logic                 q_full,
   output logic                 q_push,
   output dhct_job_type         q_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CALC = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [BYTE_W-1:0]   cnt_ff, cnt_in;
   logic [KEY_BITS-1:0] shift_ff, shift_in;
   logic [SLOT_W-1:0]   home_ff, home_in;
   logic [SLOT_W-1:0]   srem_ff, srem_in;
   dhct_job_type        job_ff, job_in;

   assign req_ready = (state_ff == F_IDLE) && !clearing;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      home_in  = home_ff;
      srem_in  = srem_ff;
      job_in   = job_ff;
      q_push   = 1'b0;
      q_data   = job_ff;
      q_data.home = home_ff;
      q_data.step = STEP_W'(STEP_PRIME) - srem_ff[STEP_W-1:0];
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               job_in.action   = req_action;
               job_in.key      = req_key;
               job_in.alt_mask = req_alt_mask[ALT_COUNT-1:0];
               shift_in = req_key;
               home_in  = '0;
               srem_in  = '0;
               cnt_in   = '0;
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            // consume the key most significant byte first
            home_in  = mod_byte(home_ff, shift_ff[KEY_BITS-1 -: 8], SLOT_W'(TABLE_SIZE));
            srem_in  = mod_byte(srem_ff, shift_ff[KEY_BITS-1 -: 8], SLOT_W'(STEP_PRIME));
            shift_in = shift_ff << 8;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == BYTE_W'(KEY_BYTES - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      home_ff  <= home_in;
      srem_ff  <= srem_in;
      job_ff   <= job_in;
   end

endmodule

FILE: rtl/dhct_queue.sv
module dhct_queue
   import dhct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  dhct_job_type push_data,
   output logic         full,
   output logic         not_empty,
   input  logic         pop,
   output dhct_job_type pop_data
);

   dhct_job_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ (push && !full);
      rd_ptr_in = rd_ptr_ff ^ (pop && not_empty);
      fill_in   = fill_ff + 2'(push && !full) - 2'(pop && not_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/dhct_back.sv
module dhct_back
   import dhct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  dhct_job_type    q_data,
   output logic            q_pop,
   output logic            clearing,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dhct_result_type rsp_data
);

   localparam logic [2:0] B_CLEAR = 3'd0;
   localparam logic [2:0] B_IDLE  = 3'd1;
   localparam logic [2:0] B_READ  = 3'd2;
   localparam logic [2:0] B_CHECK = 3'd3;
   localparam logic [2:0] B_RESP  = 3'd4;

   dhct_slot_type   slot_mem_ff [TABLE_SIZE];
   dhct_slot_type   rd_word_ff;

   logic [2:0]      state_ff, state_in;
   dhct_job_type    job_ff, job_in;
   logic [SLOT_W-1:0]  pos_ff, pos_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic [SLOT_W-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0]  clr_addr_ff, clr_addr_in;
   logic            clr_resp_ff, clr_resp_in;
   dhct_result_type res_ff, res_in;
   dhct_result_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            mem_we;
   logic [SLOT_W-1:0] mem_wa;
   dhct_slot_type   mem_wd;
   dhct_slot_type   base_word, upd_word;
   logic            hit;
   logic [SLOT_W:0] pos_sum;

   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hit     = rd_word_ff.valid && (rd_word_ff.key == job_ff.key);
   assign pos_sum = {1'b0, pos_ff} + (SLOT_W + 1)'(job_ff.step);

   // Slot contents after the increment, for a found or a fresh key.
   always_comb begin
      if (hit) begin
         base_word = rd_word_ff;
      end else begin
         base_word       = '0;
         base_word.valid = 1'b1;
         base_word.key   = job_ff.key;
      end
      upd_word = base_word;
      if (job_ff.action == ACT_INC) begin
         if (base_word.count != CNT_MAX) begin
            upd_word.count = base_word.count + 1'b1;
         end
      end else begin
         for (int j = 0; j < ALT_COUNT; j++) begin
            if (job_ff.alt_mask[j] && (base_word.alt[j] != CNT_MAX)) begin
               upd_word.alt[j] = base_word.alt[j] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      probe_in     = probe_ff;
      used_in      = used_ff;
      clr_addr_in  = clr_addr_ff;
      clr_resp_in  = clr_resp_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_wa       = pos_ff;
      mem_wd       = upd_word;
      q_pop        = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_addr_ff;
            mem_wd = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               used_in = '0;
               res_in  = '0;
               res_in.status = ST_OK;
               state_in = clr_resp_ff ? B_RESP : B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               job_in   = q_data;
               pos_in   = q_data.home;
               probe_in = '0;
               if (q_data.action == ACT_CLEAR) begin
                  clr_addr_in = '0;
                  clr_resp_in = 1'b1;
                  state_in    = B_CLEAR;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            res_in = '0;
            state_in = B_RESP;
            if (hit) begin
               res_in.status = ST_OK;
               if (job_ff.action == ACT_LOOKUP) begin
                  res_in.count = rd_word_ff.count;
                  res_in.alt   = rd_word_ff.alt;
               end else begin
                  mem_we       = 1'b1;
                  res_in.count = upd_word.count;
                  res_in.alt   = upd_word.alt;
               end
            end else if (!rd_word_ff.valid) begin
               if (job_ff.action == ACT_LOOKUP) begin
                  res_in.status = ST_NOT_FOUND;
               end else if (used_ff >= SLOT_W'(TABLE_SIZE - 1)) begin
                  res_in.status = ST_FULL;
               end else begin
                  mem_we        = 1'b1;
                  used_in       = used_ff + 1'b1;
                  res_in.status = ST_OK;
                  res_in.count  = upd_word.count;
                  res_in.alt    = upd_word.alt;
               end
            end else if (probe_ff == PROBE_W'(TABLE_SIZE - 1)) begin
               // probe bound ran out with no match and no free slot
               res_in.status = (job_ff.action == ACT_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
            end else begin
               probe_in = probe_ff + 1'b1;
               pos_in   = (pos_sum >= (SLOT_W + 1)'(TABLE_SIZE))
                        ? SLOT_W'(pos_sum - (SLOT_W + 1)'(TABLE_SIZE))
                        : pos_sum[SLOT_W-1:0];
               state_in = B_READ;
            end
         end
         B_RESP: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               clr_resp_in  = 1'b0;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_resp_ff  <= clr_resp_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff   <= job_in;
      pos_ff   <= pos_in;
      probe_ff <= probe_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
      rd_word_ff <= slot_mem_ff[pos_ff];
   end

endmodule

FILE: rtl/double_hash_counting_table_unit.sv
// Open-addressing count table of 1021 slots keyed by 64-bit integers, probed by
// double hashing. The front end reduces each key to its home slot and probe step
// one key byte a cycle, and hands the job through a two-entry queue to the back
// end, which owns the slot memory. The back end takes a job, then for each probe
// does one memory read and then the compare, and then posts the result; the
// front end of the next request overlaps it. A clear request sweeps the memory
// one slot a cycle and then posts its result; the same clearing pass runs after
// reset, with req_ready held low.
module double_hash_counting_table_unit
   import dhct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [63:0]         req_key,
   input  logic [3:0]          req_alt_mask,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_count,
   output logic [31:0]         rsp_alt_count_0,
   output logic [31:0]         rsp_alt_count_1,
   output logic [31:0]         rsp_alt_count_2,
   output logic [31:0]         rsp_alt_count_3
);

   logic            clearing;
   logic            q_full;
   logic            q_push;
   logic            q_not_empty;
   logic            q_pop;
   dhct_job_type    q_in;
   dhct_job_type    q_out;
   dhct_result_type result;

   dhct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_key     (req_key),
      .req_alt_mask(req_alt_mask),
      .clearing    (clearing),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   dhct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_data  (q_out)
   );

   dhct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (result)
   );

   assign rsp_status      = result.status;
   assign rsp_count       = result.count;
   assign rsp_alt_count_0 = result.alt[0];
   assign rsp_alt_count_1 = result.alt[1];
   assign rsp_alt_count_2 = result.alt[2];
   assign rsp_alt_count_3 = result.alt[3];

endmodule

FILE: rtl/dhct_checker.sv
`include "double_hash_counting_table_unit_assert.svh"

module dhct_checker
   import dhct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_count,
   input logic [31:0] rsp_alt_count_0,
   input logic [31:0] rsp_alt_count_1,
   input logic [31:0] rsp_alt_count_2,
   input logic [31:0] rsp_alt_count_3
);

   // hold a stalled transaction
   `DHCT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status))
   `DHCT_ASSERT(a_status_code, clock, reset, rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND)
   `DHCT_ASSERT(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_count == 0 && rsp_alt_count_0 == 0 && rsp_alt_count_1 == 0 && rsp_alt_count_2 == 0 && rsp_alt_count_3 == 0)
   // no request taken and no response offered right after a reset cycle, as the table clear begins
   `DHCT_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !req_ready && !rsp_valid)

endmodule

bind double_hash_counting_table_unit dhct_checker u_dhct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_count      (rsp_count),
   .rsp_alt_count_0(rsp_alt_count_0),
   .rsp_alt_count_1(rsp_alt_count_1),
   .rsp_alt_count_2(rsp_alt_count_2),
   .rsp_alt_count_3(rsp_alt_count_3)
);
